// File: rtl/best_mismatch_alignment_set_assert.svh
// Assertion macros for the best mismatch alignment set block.
// Included by the top level only; no other dependencies.
`ifndef BEST_MISMATCH_ALIGNMENT_SET_ASSERT_SVH
`define BEST_MISMATCH_ALIGNMENT_SET_ASSERT_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define BMAS_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
// next-cycle implication
`define BMAS_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define BMAS_ASSERT_IMPL(label, clk, rst, ante, cons)
`define BMAS_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// File: rtl/bmas_pkg.sv
// Shared types and status codes for the best mismatch alignment set.
// No dependencies.
package bmas_pkg;

  localparam logic [2:0] ST_ADDED   = 3'd0;
  localparam logic [2:0] ST_DUP     = 3'd1;
  localparam logic [2:0] ST_WORSE   = 3'd2;
  localparam logic [2:0] ST_FULL    = 3'd3;
  localparam logic [2:0] ST_CLEARED = 3'd4;

  typedef struct packed {
    logic [23:0] tid;
    logic [23:0] pos;
    logic [15:0] frag;
  } entry_t;

  typedef struct packed {
    logic rd_en;
    logic wr_en;
  } tab_req_t;

endpackage

// File: rtl/bmas_table.sv
// Entry memory with registered read port and the shared duplicate comparator.
// Depends on bmas_pkg.
module bmas_table import bmas_pkg::*; #(
  parameter int MAX_ENTRIES = 64
) (
  input  logic                           clk,
  input  tab_req_t                       req,
  input  logic [$clog2(MAX_ENTRIES)-1:0] rd_addr,
  input  logic [$clog2(MAX_ENTRIES)-1:0] wr_addr,
  input  entry_t                         wr_data,
  input  entry_t                         key,
  output logic                           match
);

  entry_t mem [MAX_ENTRIES];
  entry_t rd_data;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (req.rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  // one entry compared per cycle
  assign match = (rd_data == key);

endmodule

// File: rtl/bmas_ctrl.sv
// Sequencer: for an add, scans stored entries for a duplicate, then applies the update; a clear skips the scan.
// Depends on bmas_pkg; drives bmas_table.
module bmas_ctrl import bmas_pkg::*; #(
  parameter int MAX_ENTRIES = 64
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic                             action,
  input  logic [23:0]                      transcript_id,
  input  logic [23:0]                      start_pos,
  input  logic [15:0]                      frag_length,
  input  logic [7:0]                       mismatches,
  input  logic [7:0]                       bound,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [2:0]                       status,
  output logic [$clog2(MAX_ENTRIES+1)-1:0] entry_total,
  output logic [7:0]                       best_mm,
  output logic                             frag_discrepant,
  output tab_req_t                         req,
  output logic [$clog2(MAX_ENTRIES)-1:0]   rd_addr,
  output logic [$clog2(MAX_ENTRIES)-1:0]   wr_addr,
  output entry_t                           key,
  input  logic                             match
);

  localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
  localparam int IDX_W = $clog2(MAX_ENTRIES);
  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_ENTRIES);

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_DECIDE} state_t;

  state_t           state;
  logic             act_clr;
  logic             dup;
  logic [7:0]       mm;
  logic [CNT_W-1:0] scan_idx;
  logic [CNT_W-1:0] count;
  logic [7:0]       best;
  logic [15:0]      first_frag;
  logic             disc;

  logic             accept;
  logic             slot_free;
  logic             fire;
  logic [CNT_W-1:0] base_cnt;
  logic             can_add;

  assign in_stall  = (state != S_IDLE);
  assign accept    = in_valid && !in_stall;
  assign slot_free = !out_valid || !out_stall;
  assign fire      = (state == S_DECIDE) && slot_free;

  // a better count restarts the table at slot zero
  assign base_cnt = (mm < best) ? '0 : count;
  assign can_add  = !act_clr && !dup && (mm <= best) && (base_cnt < MAX_CNT);

  always_comb begin
    req.rd_en = (accept && !action && (count != '0)) ||
                ((state == S_SCAN) && !match && (scan_idx != count));
    req.wr_en = fire && can_add;
  end

  assign rd_addr = (state == S_IDLE) ? '0 : scan_idx[IDX_W-1:0];
  assign wr_addr = base_cnt[IDX_W-1:0];

  assign entry_total     = count;
  assign best_mm         = best;
  assign frag_discrepant = disc;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      count      <= '0;
      best       <= 8'hFF;
      first_frag <= '0;
      disc       <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (fire) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            key      <= '{tid: transcript_id, pos: start_pos, frag: frag_length};
            mm       <= mismatches;
            act_clr  <= action;
            dup      <= 1'b0;
            scan_idx <= CNT_W'(1);
            state    <= (action || (count == '0)) ? S_DECIDE : S_SCAN;
          end
        end
        S_SCAN: begin
          if (match) begin
            dup   <= 1'b1;
            state <= S_DECIDE;
          end else if (scan_idx == count) begin
            state <= S_DECIDE;
          end else begin
            scan_idx <= scan_idx + CNT_W'(1);
          end
        end
        S_DECIDE: begin
          if (slot_free) begin
            state <= S_IDLE;
            if (act_clr) begin
              count      <= '0;
              first_frag <= '0;
              disc       <= 1'b0;
              best       <= bound;
              status     <= ST_CLEARED;
            end else if (dup) begin
              status <= ST_DUP;
            end else if (mm > best) begin
              status <= ST_WORSE;
            end else if (!can_add) begin
              status <= ST_FULL;
            end else begin
              best   <= mm;
              count  <= base_cnt + CNT_W'(1);
              status <= ST_ADDED;
              if (base_cnt == '0) begin
                first_frag <= key.frag;
                disc       <= 1'b0;
              end else if (key.frag != first_frag) begin
                disc <= 1'b1;
              end
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// File: rtl/best_mismatch_alignment_set.sv
// An add scans the N stored entries for a duplicate before its result is valid (a clear
// or an empty table skips the scan, a duplicate hit ends it early); a stalled result
// holds the block. A new word is taken only once the previous result is registered at
// the output; the duplicate scan reads the single entry memory port one entry per cycle.
// Reset (rst, synchronous): table empty, best count 255, bound register 255.
module best_mismatch_alignment_set import bmas_pkg::*; #(
  parameter int MAX_ENTRIES = 64
) (
  input  logic                             clk,
  input  logic                             rst,
  // input words
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic                             action,
  input  logic [23:0]                      transcript_id,
  input  logic [23:0]                      start_pos,
  input  logic [15:0]                      frag_length,
  input  logic [7:0]                       mismatches,
  // result words
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [2:0]                       status,
  output logic [$clog2(MAX_ENTRIES+1)-1:0] entry_total,
  output logic [7:0]                       best_mm,
  output logic                             frag_discrepant,
  // bound register write
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [7:0]                       cfg_data
);

`include "best_mismatch_alignment_set_assert.svh"

  localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
  localparam int IDX_W = $clog2(MAX_ENTRIES);

  // bound loaded as best count on every clear; taken at any time
  logic [7:0] initial_mm_bound;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      initial_mm_bound <= 8'hFF;
    end else if (cfg_valid && cfg_ready) begin
      initial_mm_bound <= cfg_data;
    end
  end

  tab_req_t   req;
  logic [IDX_W-1:0] rd_addr;
  logic [IDX_W-1:0] wr_addr;
  entry_t     key;
  logic       match;

  // sequencer: one entry compared per cycle during the scan
  bmas_ctrl #(.MAX_ENTRIES(MAX_ENTRIES)) u_ctrl (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .action          (action),
    .transcript_id   (transcript_id),
    .start_pos       (start_pos),
    .frag_length     (frag_length),
    .mismatches      (mismatches),
    .bound           (initial_mm_bound),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .status          (status),
    .entry_total     (entry_total),
    .best_mm         (best_mm),
    .frag_discrepant (frag_discrepant),
    .req             (req),
    .rd_addr         (rd_addr),
    .wr_addr         (wr_addr),
    .key             (key),
    .match           (match)
  );

  // entry memory; the key doubles as write data since only the held word is stored
  bmas_table #(.MAX_ENTRIES(MAX_ENTRIES)) u_table (
    .clk     (clk),
    .req     (req),
    .rd_addr (rd_addr),
    .wr_addr (wr_addr),
    .wr_data (key),
    .key     (key),
    .match   (match)
  );

  // count never exceeds the table depth
  `BMAS_ASSERT_IMPL(a_count_max, clk, rst, 1'b1, entry_total <= CNT_W'(MAX_ENTRIES))
  // a clear result shows an empty, consistent table
  `BMAS_ASSERT_IMPL(a_clear_empty, clk, rst, out_valid && (status == ST_CLEARED),
    (entry_total == '0) && !frag_discrepant)
  // an added result always has at least one entry
  `BMAS_ASSERT_IMPL(a_added_nonzero, clk, rst, out_valid && (status == ST_ADDED),
    entry_total != '0)
  // the block is busy right after taking a word
  `BMAS_ASSERT_NEXT(a_busy_after_accept, clk, rst, in_valid && !in_stall, in_stall)

endmodule

// File: tb/tb_best_mismatch_alignment_set.sv
// Testbench for best_mismatch_alignment_set: directed words, then random reads
// checked word by word against a scoreboard that tracks the kept alignment set.
// Depends on bmas_pkg and the best_mismatch_alignment_set RTL only.
module tb_best_mismatch_alignment_set;
  timeunit 1ns;
  timeprecision 1ps;
  import bmas_pkg::*;

  localparam int MAX_ENTRIES  = 64;
  localparam int TW           = $clog2(MAX_ENTRIES + 1);
  localparam logic ACT_ADD    = 1'b0;
  localparam logic ACT_CLEAR  = 1'b1;
  localparam int ITEM_TARGET  = 1650;
  // last stretch of the run goes without any idling
  localparam int CALM_FROM    = 1450;
  // drain wait covers the worst scan over a full table, with slack on top
  localparam int DRAIN_CYCLES = MAX_ENTRIES + 16;

  // one result word as the block reports it
  typedef struct packed {
    logic [2:0]    st;
    logic [TW-1:0] total;
    logic [7:0]    best;
    logic          disc;
  } outcome_t;

  // Tracks the kept set of the current read and queues the result word that
  // each accepted input word must produce.
  class best_set_tracker;
    entry_t      kept[$];
    logic [7:0]  bound_reg;
    logic [7:0]  best_reg;
    logic [15:0] first_frag;
    logic        disc_flag;
    outcome_t    due[$];
    int          errors;

    function new();
      errors     = 0;
      bound_reg  = 8'hFF;
      best_reg   = 8'hFF;
      first_frag = '0;
      disc_flag  = 1'b0;
    endfunction

    function void empty_set();
      kept.delete();
      first_frag = '0;
      disc_flag  = 1'b0;
    endfunction

    function void load_bound(logic [7:0] v);
      bound_reg = v;
    endfunction

    function void note_word(logic act, entry_t e, logic [7:0] mm);
      outcome_t o;
      bit       dup;
      dup = 1'b0;
      if (act == ACT_CLEAR) begin
        empty_set();
        best_reg = bound_reg;
        o.st     = ST_CLEARED;
      end else begin
        foreach (kept[i]) if (kept[i] == e) dup = 1'b1;
        // duplicate wins over the mismatch test
        if (dup) begin
          o.st = ST_DUP;
        end else if (mm > best_reg) begin
          o.st = ST_WORSE;
        end else begin
          if (mm < best_reg) begin
            empty_set();
            best_reg = mm;
          end
          if (kept.size() >= MAX_ENTRIES) begin
            o.st = ST_FULL;
          end else begin
            if (kept.size() == 0) begin
              first_frag = e.frag;
              disc_flag  = 1'b0;
            end else if (e.frag != first_frag) begin
              disc_flag = 1'b1;
            end
            kept.push_back(e);
            o.st = ST_ADDED;
          end
        end
      end
      o.total = TW'(kept.size());
      o.best  = best_reg;
      o.disc  = disc_flag;
      due.push_back(o);
    endfunction

    function void check_field(string what, int unsigned want, int unsigned got);
      if (want != got) begin
        errors++;
        $display("%0t: %s mismatch: expected %0d, actual %0d", $time, what, want, got);
      end
    endfunction

    function void check_result(outcome_t got);
      outcome_t want;
      if (due.size() == 0) begin
        errors++;
        $display("%0t: result word with nothing pending: status %0d total %0d",
                 $time, got.st, got.total);
        return;
      end
      want = due.pop_front();
      check_field("status", 32'(want.st), 32'(got.st));
      check_field("entry_total", 32'(want.total), 32'(got.total));
      check_field("best_mm", 32'(want.best), 32'(got.best));
      check_field("frag_discrepant", 32'(want.disc), 32'(got.disc));
    endfunction

    function void check_drained();
      if (due.size() != 0) begin
        errors += due.size();
        $display("%0t: %0d expected result words never arrived", $time, due.size());
      end
    endfunction
  endclass

  logic          clk;
  logic          rst           = 1'b1;
  logic          in_valid      = 1'b0;
  logic          in_stall;
  logic          action        = ACT_ADD;
  logic [23:0]   transcript_id = '0;
  logic [23:0]   start_pos     = '0;
  logic [15:0]   frag_length   = '0;
  logic [7:0]    mismatches    = '0;
  logic          out_valid;
  logic          out_stall     = 1'b0;
  logic [2:0]    status;
  logic [TW-1:0] entry_total;
  logic [7:0]    best_mm;
  logic          frag_discrepant;
  logic          cfg_valid     = 1'b0;
  logic          cfg_ready;
  logic [7:0]    cfg_data      = '0;

  best_set_tracker tracker;
  int  sent;
  bit  calm;          // no idling on either side once set
  bit  gaps_on;       // sender idling allowed for the current read
  int  stall_left;
  int  quiet_left;

  best_mismatch_alignment_set #(.MAX_ENTRIES(MAX_ENTRIES)) uut (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .action          (action),
    .transcript_id   (transcript_id),
    .start_pos       (start_pos),
    .frag_length     (frag_length),
    .mismatches      (mismatches),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .status          (status),
    .entry_total     (entry_total),
    .best_mm         (best_mm),
    .frag_discrepant (frag_discrepant),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_data        (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Hard stop far beyond the slowest legal run of about 1650 words.
  initial begin
    #10_000_000;
    $display("Some tests failed");
    $finish;
  end

  // Receiver stall: random bursts, with quiet stretches mixed in.
  always @(posedge clk) begin
    if (rst || calm) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
      quiet_left <= 0;
    end else if (stall_left > 0) begin
      out_stall  <= 1'b1;
      stall_left <= stall_left - 1;
    end else if (quiet_left > 0) begin
      out_stall  <= 1'b0;
      quiet_left <= quiet_left - 1;
    end else if ($urandom_range(99) == 0) begin
      out_stall  <= 1'b0;
      quiet_left <= $urandom_range(300, 50);
    end else if ($urandom_range(4) == 0) begin
      out_stall  <= 1'b1;
      stall_left <= $urandom_range(2);
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Result monitor: pre-edge values, so no race with the NBA drivers.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall)
      tracker.check_result('{st: status, total: entry_total, best: best_mm,
                             disc: frag_discrepant});
  end

  function automatic entry_t mk(logic [23:0] tid, logic [23:0] pos, logic [15:0] frag);
    entry_t e;
    e.tid  = tid;
    e.pos  = pos;
    e.frag = frag;
    return e;
  endfunction

  // Drive one input word and hold it until accepted. Called at a rising edge;
  // returns at the accepting edge with valid still high, so back-to-back
  // words never lower and raise valid in the same step.
  task automatic send_word(logic act, entry_t e, logic [7:0] mm);
    if (!calm && gaps_on && $urandom_range(3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(3, 1)) @(posedge clk);
    end
    in_valid      <= 1'b1;
    action        <= act;
    transcript_id <= e.tid;
    start_pos     <= e.pos;
    frag_length   <= e.frag;
    mismatches    <= mm;
    do @(posedge clk); while (in_stall);
    tracker.note_word(act, e, mm);
    sent++;
    if (sent >= CALM_FROM) calm = 1'b1;
  endtask

  // Every word yields a result, so an empty queue plus a full scan time
  // means the block sits idle.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (tracker.due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_bound(logic [7:0] v);
    wait_idle();
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    tracker.load_bound(v);
    cfg_valid <= 1'b0;
  endtask

  // One read: a clear, then adds aimed around the current best count.
  // A fill read keeps the count equal so the table runs into its limit.
  task automatic run_read(int n_adds, bit fill);
    entry_t      keys[$];
    entry_t      e;
    logic [7:0]  mm;
    logic [15:0] read_frag;
    int          pick;
    int          tmp;
    read_frag = 16'($urandom);
    gaps_on   = ($urandom_range(3) != 0);
    send_word(ACT_CLEAR, mk(24'($urandom), 24'($urandom), 16'($urandom)), 8'($urandom));
    for (int i = 0; i < n_adds; i++) begin
      pick = $urandom_range(99);
      mm   = tracker.best_reg;
      e    = mk(24'($urandom), 24'($urandom),
                ($urandom_range(3) == 0) ? 16'($urandom) : read_frag);
      if (keys.size() > 0 && (fill ? pick >= 94 : pick < 12)) begin
        // resend an earlier alignment; random count hits dup-over-worse too
        e = keys[$urandom_range(keys.size() - 1)];
        if (!fill) mm = 8'($urandom);
      end else if (!fill) begin
        if (pick < 22) begin
          tmp = int'(tracker.best_reg) + $urandom_range(4, 1);
          mm  = (tmp > 255) ? 8'hFF : 8'(tmp);
        end else if (pick < 30) begin
          tmp = int'(tracker.best_reg) - $urandom_range(3, 1);
          mm  = (tmp < 0) ? 8'h00 : 8'(tmp);
        end else if (pick < 34) begin
          mm = 8'($urandom);
        end
      end
      send_word(ACT_ADD, e, mm);
      keys.push_back(e);
    end
  endtask

  initial begin
    logic [7:0] bounds[7];
    int         phase_end;
    int         per_phase;
    tracker = new();
    sent    = 0;
    calm    = 1'b0;
    gaps_on = 1'b1;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // ---- directed words, bound at its reset value 255 ----
    send_word(ACT_ADD, mk(24'h0, 24'h0, 16'h0), 8'hFF);                 // equal -> added
    send_word(ACT_ADD, mk(24'h0, 24'h0, 16'h0), 8'hFF);                 // duplicate
    send_word(ACT_ADD, mk(24'hFFFFFF, 24'hFFFFFF, 16'hFFFF), 8'hFF);    // frag differs
    send_word(ACT_ADD, mk(24'h1, 24'h2, 16'h3), 8'd10);                 // better, empties
    send_word(ACT_ADD, mk(24'h4, 24'h5, 16'h3), 8'd11);                 // worse
    send_word(ACT_ADD, mk(24'h1, 24'h2, 16'h3), 8'd200);                // dup beats worse
    send_word(ACT_ADD, mk(24'h6, 24'h7, 16'h9), 8'd10);                 // equal, discrepant
    send_word(ACT_ADD, mk(24'h6, 24'h7, 16'h8), 8'd10);                 // same site, new frag
    send_word(ACT_ADD, mk(24'hABCDEF, 24'h123456, 16'h3), 8'd0);        // better, to zero
    send_word(ACT_CLEAR, mk(24'hFFFFFF, 24'hFFFFFF, 16'hFFFF), 8'hFF);  // clear, best 255

    write_bound(8'd0);
    // new bound only takes effect at the next clear
    send_word(ACT_ADD, mk(24'h2, 24'h2, 16'h2), 8'hFF);
    send_word(ACT_CLEAR, mk(24'h0, 24'h0, 16'h0), 8'h0);
    send_word(ACT_ADD, mk(24'hFFFFFF, 24'h0, 16'hFFFF), 8'd0);
    send_word(ACT_ADD, mk(24'h0, 24'hFFFFFF, 16'hFFFF), 8'd0);
    send_word(ACT_ADD, mk(24'h5, 24'h5, 16'h5), 8'hFF);                 // worse
    send_word(ACT_ADD, mk(24'hFFFFFF, 24'h0, 16'hFFFF), 8'hFF);         // dup beats worse
    send_word(ACT_ADD, mk(24'h5, 24'h5, 16'h5), 8'd1);                  // worse by one

    // ---- random reads over several bound settings ----
    bounds[0] = 8'hFF;
    bounds[1] = 8'd0;
    bounds[2] = 8'($urandom);
    bounds[3] = 8'd1;
    bounds[4] = 8'd254;
    bounds[5] = 8'($urandom);
    bounds[6] = 8'd128;
    per_phase = (ITEM_TARGET - sent) / 7;
    for (int p = 0; p < 7; p++) begin
      write_bound(bounds[p]);
      phase_end = sent + per_phase;
      // start every phase with a fill read aimed at a full table
      run_read($urandom_range(72, 66), 1'b1);
      while (sent < phase_end) begin
        if ($urandom_range(19) == 0) begin
          // stray word outside the read structure
          send_word(1'($urandom), mk(24'($urandom), 24'($urandom), 16'($urandom)),
                    8'($urandom));
        end else if ($urandom_range(7) == 0) begin
          run_read($urandom_range(72, 66), 1'b1);
        end else begin
          run_read($urandom_range(24, 1), 1'b0);
        end
      end
    end

    // ---- drain and report ----
    wait_idle();
    tracker.check_drained();
    if (tracker.errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// File: sim.f
+incdir+rtl
rtl/bmas_pkg.sv
rtl/bmas_table.sv
rtl/bmas_ctrl.sv
rtl/best_mismatch_alignment_set.sv
tb/tb_best_mismatch_alignment_set.sv
